### hdl/ppda_pkg.sv
// ----------------------------------------------------------------------------
// ppda_pkg: shared types and constants for the point pair direction block
// holds the arctangent table, angle scale factors and the pipeline side-band
// ----------------------------------------------------------------------------
`default_nettype none

package ppda_pkg;

  // default configuration
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // fixed-point layout
  localparam int GUARD_BITS   = 20;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_W       = 30;
  localparam int ZW           = 33;   // signed angle accumulator, 2^-32 turn
  localparam int QW           = 31;   // clamped first-quadrant angle
  localparam int TURN_W       = 32;   // full-circle angle, 2^-32 turn
  localparam int PROD_W       = 64;
  localparam int ROUND_POS    = 48;
  localparam int RES_W        = PROD_W + 1 - ROUND_POS;
  localparam int OUT_W        = 16;

  // quarter-turn codes for points on an axis
  localparam logic [1:0] QTR_E = 2'd0;
  localparam logic [1:0] QTR_N = 2'd1;
  localparam logic [1:0] QTR_W = 2'd2;
  localparam logic [1:0] QTR_S = 2'd3;

  // angle unit codes
  localparam logic UNIT_DEG = 1'b0;
  localparam logic UNIT_RAD = 1'b1;

  // turn constants
  localparam logic [ZW-1:0]     QUARTER_TURN = ZW'(64'd1073741824);
  localparam logic [TURN_W:0]   HALF_TURN    = 33'd2147483648;
  localparam logic [TURN_W:0]   FULL_TURN    = 33'd4294967296;

  // unit conversion: degrees scale is 46080 pre-shifted by 16 so both
  // units round at the same bit position
  localparam logic [TURN_W-1:0] DEG_SCALE  = 32'd3019898880;
  localparam logic [TURN_W-1:0] RAD_SCALE  = 32'd3373259426;
  localparam logic [PROD_W:0]   ROUND_BIAS = 65'd140737488355328;
  localparam logic [RES_W-1:0]  DEG_WRAP   = 17'd46080;
  localparam logic [RES_W-1:0]  RAD_WRAP   = 17'd51472;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ATAN_W-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  // side-band that travels with each item down the cell chain
  typedef struct packed {
    logic       axis;
    logic [1:0] quarter;
    logic       wneg;
    logic       hneg;
  } ppda_meta_t;

endpackage

`default_nettype wire

### hdl/ppda_prep.sv
// ----------------------------------------------------------------------------
// ppda_prep: coordinate difference stage
// forms the offset vector, its magnitudes and the axis / quadrant side-band
// ----------------------------------------------------------------------------
`default_nettype none

module ppda_prep #(
  parameter int COORD_WIDTH = ppda_pkg::COORD_WIDTH_DEF,
  parameter int XW          = ppda_pkg::COORD_WIDTH_DEF + ppda_pkg::GUARD_BITS + 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          out_x,
  output logic signed [XW-1:0]          out_y,
  output ppda_pkg::ppda_meta_t          out_meta
);
  import ppda_pkg::*;

  logic signed [COORD_WIDTH:0] w;
  logic signed [COORD_WIDTH:0] h;
  logic        [COORD_WIDTH:0] wmag;
  logic        [COORD_WIDTH:0] hmag;
  ppda_meta_t                  meta_next;
  logic                        valid;
  logic signed [XW-1:0]        x;
  logic signed [XW-1:0]        y;
  ppda_meta_t                  meta;

  // offset vector, h positive pointing up on screen
  assign w    = $signed({target_x[COORD_WIDTH-1], target_x})
              - $signed({start_x[COORD_WIDTH-1], start_x});
  assign h    = $signed({start_y[COORD_WIDTH-1], start_y})
              - $signed({target_y[COORD_WIDTH-1], target_y});
  assign wmag = w[COORD_WIDTH] ? (~w + 1'b1) : w;
  assign hmag = h[COORD_WIDTH] ? (~h + 1'b1) : h;

  // axis and quadrant classification
  always_comb begin
    meta_next.wneg    = w[COORD_WIDTH];
    meta_next.hneg    = h[COORD_WIDTH];
    meta_next.axis    = 1'b1;
    meta_next.quarter = QTR_E;
    if (w == '0 && h == '0) begin
      meta_next.quarter = QTR_E;
    end else if (w == '0) begin
      meta_next.quarter = h[COORD_WIDTH] ? QTR_S : QTR_N;
    end else if (h == '0) begin
      meta_next.quarter = w[COORD_WIDTH] ? QTR_W : QTR_E;
    end else begin
      meta_next.axis = 1'b0;
    end
  end

  assign in_ready = !valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload, magnitudes scaled up by the guard bits
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x    <= $signed(XW'({wmag, {GUARD_BITS{1'b0}}}));
      y    <= $signed(XW'({hmag, {GUARD_BITS{1'b0}}}));
      meta <= meta_next;
    end
  end

  assign out_valid = valid;
  assign out_x     = x;
  assign out_y     = y;
  assign out_meta  = meta;

endmodule

`default_nettype wire

### hdl/ppda_cell.sv
// ----------------------------------------------------------------------------
// ppda_cell: one vectoring rotation of the arctangent chain
// rotates (x, y) toward the x axis by atan(2^-STAGE) and tracks the angle
// ----------------------------------------------------------------------------
`default_nettype none

module ppda_cell #(
  parameter int XW    = ppda_pkg::COORD_WIDTH_DEF + ppda_pkg::GUARD_BITS + 4,
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [XW-1:0]          in_x,
  input  logic signed [XW-1:0]          in_y,
  input  logic signed [ppda_pkg::ZW-1:0] in_z,
  input  ppda_pkg::ppda_meta_t          in_meta,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          out_x,
  output logic signed [XW-1:0]          out_y,
  output logic signed [ppda_pkg::ZW-1:0] out_z,
  output ppda_pkg::ppda_meta_t          out_meta
);
  import ppda_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = $signed(ZW'(ATAN_TURN[STAGE]));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;
  logic                 valid;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  ppda_meta_t           meta;

  // shifted operands, arithmetic shift floors negative values
  assign xs = in_x >>> STAGE;
  assign ys = in_y >>> STAGE;

  // rotate in the direction that drives y toward zero
  always_comb begin
    if (!in_y[XW-1]) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ANGLE;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ANGLE;
    end
  end

  assign in_ready = !valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      meta <= in_meta;
    end
  end

  assign out_valid = valid;
  assign out_x     = x;
  assign out_y     = y;
  assign out_z     = z;
  assign out_meta  = meta;

endmodule

`default_nettype wire

### hdl/ppda_finish.sv
// ----------------------------------------------------------------------------
// ppda_finish: quadrant fold and unit conversion
// clamps the chain angle, folds it into the full circle, scales and rounds
// ----------------------------------------------------------------------------
`default_nettype none

module ppda_finish (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           angle_unit,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ppda_pkg::ZW-1:0] in_z,
  input  ppda_pkg::ppda_meta_t           in_meta,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppda_pkg::OUT_W-1:0]     direction
);
  import ppda_pkg::*;

  logic [QW-1:0]     q;
  logic [TURN_W:0]   t_next;
  logic [PROD_W:0]   rounded;
  logic [RES_W-1:0]  r;
  logic [RES_W-1:0]  wrap;
  logic              en_a;
  logic              en_b;
  logic              en_c;
  logic              valid_a;
  logic              valid_b;
  logic              valid_c;
  logic [TURN_W-1:0] t;
  logic [PROD_W-1:0] prod;
  logic              unit_b;
  logic [OUT_W-1:0]  result;

  // clamp the accumulated angle to one quarter turn
  always_comb begin
    if (in_z[ZW-1]) begin
      q = '0;
    end else if (in_z > $signed(QUARTER_TURN)) begin
      q = QW'(QUARTER_TURN);
    end else begin
      q = in_z[QW-1:0];
    end
  end

  // fold into the quadrant of the offset vector
  always_comb begin
    if (in_meta.axis) begin
      t_next = {1'b0, in_meta.quarter, {(TURN_W - 2){1'b0}}};
    end else if (!in_meta.wneg && !in_meta.hneg) begin
      t_next = (TURN_W + 1)'(q);
    end else if (in_meta.wneg && !in_meta.hneg) begin
      t_next = HALF_TURN - (TURN_W + 1)'(q);
    end else if (in_meta.wneg) begin
      t_next = HALF_TURN + (TURN_W + 1)'(q);
    end else begin
      t_next = FULL_TURN - (TURN_W + 1)'(q);
    end
  end

  // round to the output step and wrap a full turn to zero
  assign rounded = {1'b0, prod} + ROUND_BIAS;
  assign r       = rounded[PROD_W:ROUND_POS];
  assign wrap    = (unit_b == UNIT_RAD) ? RAD_WRAP : DEG_WRAP;

  always_comb begin
    if (r >= wrap) begin
      result = '0;
    end else begin
      result = r[OUT_W-1:0];
    end
  end

  // per-stage advance
  assign en_c     = !valid_c || out_ready;
  assign en_b     = !valid_b || en_c;
  assign en_a     = !valid_a || en_b;
  assign in_ready = en_a;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (en_a) begin
        valid_a <= in_valid;
      end
      if (en_b) begin
        valid_b <= valid_a;
      end
      if (en_c) begin
        valid_c <= valid_b;
      end
    end
  end

  // folded angle
  always_ff @(posedge clk) begin
    if (in_valid && en_a) begin
      t <= t_next[TURN_W-1:0];
    end
  end

  // unit scaling product, 32 by 32 bits into a 64-bit result
  always_ff @(posedge clk) begin
    if (valid_a && en_b) begin
      prod   <= PROD_W'(t)
              * PROD_W'((angle_unit == UNIT_RAD) ? RAD_SCALE : DEG_SCALE);
      unit_b <= angle_unit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (valid_b && en_c) begin
      direction <= result;
    end
  end

  assign out_valid = valid_c;

endmodule

`default_nettype wire

### hdl/point_pair_direction_angle.sv
// ----------------------------------------------------------------------------
// point_pair_direction_angle: full-circle direction between two screen points
// pipelined vectoring arctangent with quadrant fold and degree/radian output
// ----------------------------------------------------------------------------
//
//   channel     signals                                  role
//   pair        pair_valid / pair_ready, start/target    point pair item in
//   direction   direction_valid / direction_ready        angle item out
//   cfg         cfg_we / cfg_data                        angle unit register
//
// one item per clock while direction_ready stays high; the stages in order are the
// difference stage, one cell per rotation, then the fold, multiply and rounding stages
// every stage has its own valid flag, so a stall on the output fills the
// bubbles upstream before pair_ready drops
// synchronous reset clears all valid flags and sets the unit to degrees
`default_nettype none

module point_pair_direction_angle #(
  parameter int COORD_WIDTH   = ppda_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = ppda_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic                          pair_valid,
  output logic                          pair_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  output logic                          direction_valid,
  input  logic                          direction_ready,
  output logic [ppda_pkg::OUT_W-1:0]    direction
);
  import ppda_pkg::*;

  localparam int XW = COORD_WIDTH + GUARD_BITS + 4;

  logic                 angle_unit;
  logic                 valid_chain [CORDIC_STAGES+1];
  logic                 ready_chain [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_chain     [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_chain     [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_chain     [CORDIC_STAGES+1];
  ppda_meta_t           meta_chain  [CORDIC_STAGES+1];

  // unit register
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_unit <= UNIT_DEG;
    end else if (cfg_we) begin
      angle_unit <= cfg_data;
    end
  end

  // offset vector and side-band
  ppda_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pair_valid),
    .in_ready  (pair_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .target_x  (target_x),
    .target_y  (target_y),
    .out_valid (valid_chain[0]),
    .out_ready (ready_chain[0]),
    .out_x     (x_chain[0]),
    .out_y     (y_chain[0]),
    .out_meta  (meta_chain[0])
  );

  assign z_chain[0] = '0;

  // rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ppda_cell #(
      .XW    (XW),
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[i]),
      .in_ready  (ready_chain[i]),
      .in_x      (x_chain[i]),
      .in_y      (y_chain[i]),
      .in_z      (z_chain[i]),
      .in_meta   (meta_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_ready (ready_chain[i+1]),
      .out_x     (x_chain[i+1]),
      .out_y     (y_chain[i+1]),
      .out_z     (z_chain[i+1]),
      .out_meta  (meta_chain[i+1])
    );
  end

  // fold, scale and output register
  ppda_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .angle_unit (angle_unit),
    .in_valid   (valid_chain[CORDIC_STAGES]),
    .in_ready   (ready_chain[CORDIC_STAGES]),
    .in_z       (z_chain[CORDIC_STAGES]),
    .in_meta    (meta_chain[CORDIC_STAGES]),
    .out_valid  (direction_valid),
    .out_ready  (direction_ready),
    .direction  (direction)
  );

endmodule

`default_nettype wire

### hdl/ppda_checker.sv
// ----------------------------------------------------------------------------
// ppda_checker: port-level checks for the point pair direction block
// watches the output channel and the unit register writes
// ----------------------------------------------------------------------------
`default_nettype none

module ppda_checker (
  input wire        clk,
  input wire        rst,
  input wire        cfg_we,
  input wire        cfg_data,
  input wire        direction_valid,
  input wire        direction_ready,
  input wire [15:0] direction
);

  logic unit_seen;

  // shadow of the unit register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_seen <= 1'b0;
    end else if (cfg_we) begin
      unit_seen <= cfg_data;
    end
  end

  // a waiting item holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    direction_valid && !direction_ready |=> direction_valid && $stable(direction))
    else $error("direction item changed while stalled");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !direction_valid)
    else $error("direction_valid high after reset");

  // degree results stay below a full turn
  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    direction_valid && !unit_seen |-> direction < 16'd46080)
    else $error("degree result out of range");

  // radian results stay below a full turn
  a_rad_range: assert property (@(posedge clk) disable iff (rst)
    direction_valid && unit_seen |-> direction < 16'd51472)
    else $error("radian result out of range");

endmodule

bind point_pair_direction_angle ppda_checker u_ppda_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_we          (cfg_we),
  .cfg_data        (cfg_data),
  .direction_valid (direction_valid),
  .direction_ready (direction_ready),
  .direction       (direction)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for point_pair_direction_angle
// drives point pairs under random sender gaps and receiver stalls in both
// angle units, predicts every direction item with an in-bench arctangent
// model and compares each returned item against it in order
// ----------------------------------------------------------------------------

module tb;

  localparam int CW         = ppda_pkg::COORD_WIDTH_DEF;
  localparam int STAGES     = ppda_pkg::CORDIC_STAGES_DEF;
  localparam int OUT_W      = ppda_pkg::OUT_W;
  localparam int LATENCY    = STAGES + 4;
  localparam int LIMIT      = 200000;
  localparam int SCALE_BITS = 20;
  localparam int CMAX       = 2 ** (CW - 1) - 1;
  localparam int CMIN       = -(2 ** (CW - 1));

  localparam longint unsigned QUARTER = 64'd1 << 30;
  localparam longint unsigned HALF    = 64'd1 << 31;
  localparam longint unsigned FULL    = 64'd1 << 32;

  // atan(2^-i) in 2^-32 turn
  localparam longint ATAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // point pairs for the directed part: start_x, start_y, target_x, target_y
  localparam int DIRECTED [12][4] = '{
    '{0, 0, 0, 0},
    '{-32768, 32767, -32768, 32767},
    '{-32768, 0, 32767, 0},
    '{32767, 5, -32768, 5},
    '{0, 32767, 0, -32768},
    '{-7, -32768, -7, 32767},
    '{0, 0, 100, -100},
    '{32767, 32767, -32768, -32768},
    '{1, -1, 0, 0},
    '{-32768, 0, 32767, 1},
    '{-32768, 1, 32767, 0},
    '{0, 32767, 1, -32768}
  };

  typedef logic signed [CW-1:0] coord_t;

  // expected direction items and the unit they are computed in
  class direction_scoreboard;
    logic             unit;
    logic [OUT_W-1:0] expected_q [$];
    int               errors;
    int               noted;
    int               checked;

    function new();
      unit    = ppda_pkg::UNIT_DEG;
      errors  = 0;
      noted   = 0;
      checked = 0;
    endfunction

    task report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    // vectoring rotation, first-quadrant angle of (a, b) in 2^-32 turn
    function longint quadrant_turn(longint a, longint b);
      longint x, y, z, xs, ys;
      x = a <<< SCALE_BITS;
      y = b <<< SCALE_BITS;
      z = 0;
      for (int i = 0; i < STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(QUARTER)) z = longint'(QUARTER);
      return z;
    endfunction

    // full-circle direction of one point pair in the current unit
    function logic [OUT_W-1:0] pair_direction(coord_t sx, coord_t sy, coord_t tx,
                                               coord_t ty);
      longint          w, h;
      longint unsigned q, t, r;
      w = longint'(tx) - longint'(sx);
      h = longint'(sy) - longint'(ty);
      if (w == 0 && h == 0) begin
        t = 0;
      end else if (w == 0) begin
        t = (h > 0) ? QUARTER : 3 * QUARTER;
      end else if (h == 0) begin
        t = (w > 0) ? 0 : HALF;
      end else begin
        q = longint'(quadrant_turn(w < 0 ? -w : w, h < 0 ? -h : h));
        if (w > 0 && h > 0) t = q;
        else if (w < 0 && h > 0) t = HALF - q;
        else if (w < 0) t = HALF + q;
        else t = (FULL - q) & 64'hFFFF_FFFF;
      end
      // round half up, a full turn wraps to zero
      if (unit == ppda_pkg::UNIT_RAD) begin
        r = (t * 64'd3373259426 + (64'd1 << 47)) >> 48;
        if (r >= 51472) r = 0;
      end else begin
        r = (t * 64'd46080 + (64'd1 << 31)) >> 32;
        if (r >= 46080) r = 0;
      end
      return r[OUT_W-1:0];
    endfunction

    function void note_pair(coord_t sx, coord_t sy, coord_t tx, coord_t ty);
      expected_q.push_back(pair_direction(sx, sy, tx, ty));
      noted++;
    endfunction

    task check_direction(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("direction %0d with no item outstanding", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("direction item %0d: got %0d, want %0d", checked, got, want));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    task finish_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d direction items never returned", expected_q.size()));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_data = 1'b0;
  logic             pair_valid = 1'b0;
  logic             pair_ready;
  coord_t           start_x = '0;
  coord_t           start_y = '0;
  coord_t           target_x = '0;
  coord_t           target_y = '0;
  logic             direction_valid;
  logic             direction_ready = 1'b0;
  logic [OUT_W-1:0] direction;

  int gap_pct = 23;
  int stall_pct = 77;
  int cycle_count = 0;
  int unit_writes = 0;

  direction_scoreboard sb = new();

  point_pair_direction_angle dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .pair_valid      (pair_valid),
    .pair_ready      (pair_ready),
    .start_x         (start_x),
    .start_y         (start_y),
    .target_x        (target_x),
    .target_y        (target_y),
    .direction_valid (direction_valid),
    .direction_ready (direction_ready),
    .direction       (direction)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // direction side: check accepted items, then pick the next ready
  always @(posedge clk) begin
    if (!rst && direction_valid && direction_ready)
      sb.check_direction(direction);
    direction_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one point pair item, with a random gap in front
  task automatic send_pair(coord_t sx, coord_t sy, coord_t tx, coord_t ty);
    if ($urandom_range(99) < gap_pct) begin
      pair_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    pair_valid <= 1'b1;
    start_x    <= sx;
    start_y    <= sy;
    target_x   <= tx;
    target_y   <= ty;
    do @(posedge clk); while (!pair_ready);
    sb.note_pair(sx, sy, tx, ty);
  endtask

  // hold off input until every outstanding direction has come back
  task automatic drain_pairs();
    pair_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // unit change only with the pipeline empty
  task automatic write_unit(logic u);
    drain_pairs();
    repeat (LATENCY) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= u;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.unit = u;
    unit_writes++;
  endtask

  task automatic run_directed();
    for (int i = 0; i < 12; i++)
      send_pair(coord_t'(DIRECTED[i][0]), coord_t'(DIRECTED[i][1]),
                coord_t'(DIRECTED[i][2]), coord_t'(DIRECTED[i][3]));
  endtask

  function automatic coord_t extreme_coord();
    case ($urandom_range(6))
      0: return coord_t'(CMIN);
      1: return coord_t'(CMIN + 1);
      2: return coord_t'(-1);
      3: return coord_t'(0);
      4: return coord_t'(1);
      5: return coord_t'(CMAX - 1);
      default: return coord_t'(CMAX);
    endcase
  endfunction

  // a coordinate a few steps from s, kept in range
  function automatic coord_t near_coord(coord_t s);
    int d, v;
    d = int'($urandom_range(16)) - 8;
    v = int'(s) + d;
    if (v > CMAX || v < CMIN) v = int'(s) - d;
    return coord_t'(v);
  endfunction

  // random pairs: mostly full range, some close together, on an axis or extreme
  task automatic run_random(int count);
    coord_t sx, sy, tx, ty;
    int     kind;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_pairs();
      kind = $urandom_range(99);
      sx = coord_t'($urandom());
      sy = coord_t'($urandom());
      tx = coord_t'($urandom());
      ty = coord_t'($urandom());
      if (kind >= 90) begin
        sx = extreme_coord();
        sy = extreme_coord();
        tx = extreme_coord();
        ty = extreme_coord();
      end else if (kind >= 80) begin
        case ($urandom_range(2))
          0: tx = sx;
          1: ty = sy;
          default: begin
            tx = sx;
            ty = sy;
          end
        endcase
      end else if (kind >= 60) begin
        tx = near_coord(sx);
        ty = near_coord(sy);
      end
      send_pair(sx, sy, tx, ty);
    end
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_unit(ppda_pkg::UNIT_RAD);
    run_directed();
    write_unit(ppda_pkg::UNIT_DEG);
    run_directed();

    write_unit(ppda_pkg::UNIT_RAD);
    run_random(170);

    gap_pct   = 77;
    stall_pct = 23;
    write_unit(ppda_pkg::UNIT_DEG);
    run_random(170);

    gap_pct   = 0;
    stall_pct = 0;
    write_unit(ppda_pkg::UNIT_RAD);
    run_random(170);

    drain_pairs();
    repeat (LATENCY + 8) @(posedge clk);
    sb.finish_check();

    $display("tb: %0d point pairs sent, %0d directions checked, %0d unit writes",
             sb.noted, sb.checked, unit_writes);
    $display("tb: covered equal points, axes, full-turn wrap, both units, stalls");
    if (sb.errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
